// File: rtl/thermal_throttle_estimator_top_macros.svh
// assertion helpers for the top module, the only module that includes them
`ifndef THERMAL_THROTTLE_ESTIMATOR_TOP_MACROS_SVH
`define THERMAL_THROTTLE_ESTIMATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tte_pkg.sv
`default_nettype none

package tte_pkg;

    localparam int PC_W = 3;

    localparam logic [15:0] AMBIENT_RST    = 16'd8960;
    localparam logic [15:0] RESIST_RST     = 16'd3840;
    localparam logic [15:0] ALPHA_RST      = 16'd544;
    localparam logic [15:0] THROTTLE_RST   = 16'd17920;
    localparam logic [15:0] CRITICAL_RST   = 16'd21760;
    localparam logic [15:0] FULL_SPEED     = 16'd32768;
    localparam logic [15:0] TEMP_MAX       = 16'hFFFF;
    localparam logic [31:0] EVENTS_MAX     = 32'hFFFF_FFFF;
    localparam logic [3:0]  DIV_LAST_BIT   = 4'd14;

    typedef enum logic [2:0] {
        REG_AMBIENT  = 3'd0,
        REG_RESIST   = 3'd1,
        REG_ALPHA    = 3'd2,
        REG_THROTTLE = 3'd3,
        REG_CRITICAL = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_MUL_RISE = 3'd1,
        OP_STEADY   = 3'd2,
        OP_MUL_DIFF = 3'd3,
        OP_APPLY    = 3'd4,
        OP_CLASS    = 3'd5,
        OP_DIV      = 3'd6,
        OP_FIN      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE      = 2'd0,
        COND_BAND_EXIT = 2'd1,
        COND_DIV_MORE  = 2'd2,
        COND_EMIT      = 2'd3
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic band_exit;
        logic div_more;
    } status_t;

    typedef struct packed {
        logic [15:0] temp;
        logic [15:0] throttle;
        logic        critical;
        logic [31:0] events;
    } state_t;

    typedef struct packed {
        logic [15:0] ambient;
        logic [15:0] resist;
        logic [15:0] alpha;
        logic [15:0] throttle_temp;
        logic [15:0] critical_temp;
    } cfg_t;

    // microprogram: one control word per step
    function automatic ctrl_t prog_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: COND_NONE, target: 3'd0};
        case (pc)
            3'd0: w = '{op: OP_MUL_RISE, cond: COND_NONE,      target: 3'd0};
            3'd1: w = '{op: OP_STEADY,   cond: COND_NONE,      target: 3'd0};
            3'd2: w = '{op: OP_MUL_DIFF, cond: COND_NONE,      target: 3'd0};
            3'd3: w = '{op: OP_APPLY,    cond: COND_NONE,      target: 3'd0};
            3'd4: w = '{op: OP_CLASS,    cond: COND_BAND_EXIT, target: 3'd7};
            3'd5: w = '{op: OP_DIV,      cond: COND_DIV_MORE,  target: 3'd5};
            3'd6: w = '{op: OP_FIN,      cond: COND_NONE,      target: 3'd0};
            3'd7: w = '{op: OP_NOP,      cond: COND_EMIT,      target: 3'd0};
            default: w = '{op: OP_NOP,   cond: COND_EMIT,      target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tte_seq.sv
`default_nettype none

module tte_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            emit_ok,
    input  wire tte_pkg::status_t status,
    output tte_pkg::ctrl_t       ctrl,
    output logic                 busy,
    output logic                 emit
);
    import tte_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            busy_reg, busy_next;
    ctrl_t           word;
    logic            taken;

    always_comb
    begin
        word = prog_rom(pc_reg);
        unique case (word.cond)
            COND_NONE:      taken = 1'b0;
            COND_BAND_EXIT: taken = status.band_exit;
            COND_DIV_MORE:  taken = status.div_more;
            COND_EMIT:      taken = 1'b0;
            default:        taken = 1'b0;
        endcase

        emit = busy_reg && (word.cond == COND_EMIT) && emit_ok;

        ctrl = word;
        if (!busy_reg)
        begin
            ctrl.op = OP_NOP;
        end

        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (busy_reg)
        begin
            if (word.cond == COND_EMIT)
            begin
                // hold on the last step until the output register is free
                if (emit_ok)
                begin
                    busy_next = 1'b0;
                    pc_next   = '0;
                end
            end
            else if (taken)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tte_datapath.sv
`default_nettype none

module tte_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [15:0]     power,
    input  wire tte_pkg::cfg_t   cfg,
    input  wire tte_pkg::ctrl_t  ctrl,
    output tte_pkg::status_t     status,
    output tte_pkg::state_t      state
);
    import tte_pkg::*;

    // architectural state
    logic [15:0] temp_reg, temp_next;
    logic [15:0] throttle_reg, throttle_next;
    logic        crit_reg, crit_next;
    logic [31:0] events_reg, events_next;

    // working registers
    logic [15:0] power_reg, power_next;
    logic [31:0] prod_reg, prod_next;
    logic [15:0] steady_reg, steady_next;
    logic        up_reg, up_next;
    logic [15:0] rem_reg, rem_next;
    logic [14:0] quo_reg, quo_next;
    logic [15:0] range_reg, range_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic [16:0] steady_sum;
    logic [32:0] rounded;
    logic [16:0] step;
    logic [16:0] up_sum;
    logic        at_crit, in_band;
    logic [16:0] shifted;

    always_comb
    begin
        steady_sum = {1'b0, cfg.ambient} + {1'b0, prod_reg[27:12]}
                     + {prod_reg[31:28], 13'd0};
        rounded    = {1'b0, prod_reg} + 33'd32768;
        step       = rounded[32:16];
        up_sum     = {1'b0, temp_reg} + step;
        at_crit    = temp_reg >= cfg.critical_temp;
        in_band    = !at_crit && (temp_reg >= cfg.throttle_temp);
        shifted    = {rem_reg, 1'b0};

        status.band_exit = !in_band;
        status.div_more  = cnt_reg != 4'd0;

        temp_next     = temp_reg;
        throttle_next = throttle_reg;
        crit_next     = crit_reg;
        events_next   = events_reg;
        power_next    = power_reg;
        prod_next     = prod_reg;
        steady_next   = steady_reg;
        up_next       = up_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        range_next    = range_reg;
        cnt_next      = cnt_reg;

        if (start)
        begin
            power_next = power;
        end

        case (ctrl.op)
            OP_MUL_RISE:
            begin
                prod_next = {16'd0, power_reg} * {16'd0, cfg.resist};
            end
            OP_STEADY:
            begin
                // rise can exceed 16 bits, so any top bit saturates
                if (steady_sum[16] || (prod_reg[31:28] != 4'd0))
                begin
                    steady_next = TEMP_MAX;
                end
                else
                begin
                    steady_next = steady_sum[15:0];
                end
            end
            OP_MUL_DIFF:
            begin
                up_next = steady_reg >= temp_reg;
                if (steady_reg >= temp_reg)
                begin
                    prod_next = {16'd0, steady_reg - temp_reg} * {16'd0, cfg.alpha};
                end
                else
                begin
                    prod_next = {16'd0, temp_reg - steady_reg} * {16'd0, cfg.alpha};
                end
            end
            OP_APPLY:
            begin
                if (up_reg)
                begin
                    temp_next = up_sum[16] ? TEMP_MAX : up_sum[15:0];
                end
                else if (step >= {1'b0, temp_reg})
                begin
                    temp_next = '0;
                end
                else
                begin
                    temp_next = temp_reg - step[15:0];
                end
            end
            OP_CLASS:
            begin
                if (at_crit)
                begin
                    throttle_next = '0;
                    crit_next     = 1'b1;
                end
                else if (in_band)
                begin
                    rem_next   = temp_reg - cfg.throttle_temp;
                    range_next = cfg.critical_temp - cfg.throttle_temp;
                    quo_next   = '0;
                    cnt_next   = DIV_LAST_BIT;
                    if (events_reg != EVENTS_MAX)
                    begin
                        events_next = events_reg + 32'd1;
                    end
                end
                else
                begin
                    throttle_next = FULL_SPEED;
                end
            end
            OP_DIV:
            begin
                // restoring division, one quotient bit per step
                if (shifted >= {1'b0, range_reg})
                begin
                    rem_next = shifted[15:0] - range_reg;
                    quo_next = {quo_reg[13:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[15:0];
                    quo_next = {quo_reg[13:0], 1'b0};
                end
                cnt_next = cnt_reg - 4'd1;
            end
            OP_FIN:
            begin
                throttle_next = FULL_SPEED - {1'b0, quo_reg};
            end
            default:
            begin
            end
        endcase

        state.temp     = temp_reg;
        state.throttle = throttle_reg;
        state.critical = crit_reg;
        state.events   = events_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg     <= AMBIENT_RST;
            throttle_reg <= FULL_SPEED;
            crit_reg     <= 1'b0;
            events_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            temp_reg     <= temp_next;
            throttle_reg <= throttle_next;
            crit_reg     <= crit_next;
            events_reg   <= events_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        power_reg  <= power_next;
        prod_reg   <= prod_next;
        steady_reg <= steady_next;
        up_reg     <= up_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        range_reg  <= range_next;
    end

endmodule

`default_nettype wire

// File: rtl/thermal_throttle_estimator_top.sv
`default_nettype none

// First-order thermal estimator with a linear throttle band. Each power sample
// (Q4.12 W) moves the stored Q8.8 temperature toward ambient + power * R by the
// factor alpha, then yields a Q1.15 throttle, a sticky critical flag and a
// saturating count of samples that fell in the band. A sample whose new
// temperature is below the band or at or above critical skips the divider;
// inside the band the 15 steps of the restoring divider run before the
// throttle is computed. A new sample is taken once the microprogram has
// loaded the previous result into the output register.
// Configuration writes take effect at once and belong between samples.
module thermal_throttle_estimator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] power
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [15:0] temperature_now, [31:16] throttle,
                                        // [32] is_critical, [64:33] event_count
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import tte_pkg::*;

    `include "thermal_throttle_estimator_top_macros.svh"

    cfg_t    cfg_reg, cfg_next;
    ctrl_t   ctrl;
    status_t status;
    state_t  state;
    logic    busy, emit, start, emit_ok;

    logic    out_valid_reg, out_valid_next;
    state_t  out_reg, out_next;

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign emit_ok  = !out_valid_reg || m_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AMBIENT:  cfg_next.ambient       = cfg_data;
                REG_RESIST:   cfg_next.resist        = cfg_data;
                REG_ALPHA:    cfg_next.alpha         = cfg_data;
                REG_THROTTLE: cfg_next.throttle_temp = cfg_data;
                REG_CRITICAL: cfg_next.critical_temp = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ambient: AMBIENT_RST, resist: RESIST_RST, alpha: ALPHA_RST,
                         throttle_temp: THROTTLE_RST, critical_temp: CRITICAL_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tte_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .emit_ok (emit_ok),
        .status  (status),
        .ctrl    (ctrl),
        .busy    (busy),
        .emit    (emit)
    );

    tte_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .power  (s_tdata),
        .cfg    (cfg_reg),
        .ctrl   (ctrl),
        .status (status),
        .state  (state)
    );

    // output register, refilled in the same cycle its transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.events, out_reg.critical,
                       out_reg.throttle, out_reg.temp};

    `TTE_ASSERT_IMP(a_emit_free, emit, (!out_valid_reg || m_tready), "result loaded over a pending one")
    `TTE_ASSERT_IMP(a_throttle_range, 1'b1, (state.throttle <= FULL_SPEED), "throttle above full speed")
    `TTE_ASSERT_NEXT(a_crit_sticky, state.critical, state.critical, "critical flag cleared")
    `TTE_ASSERT_NEXT(a_events_mono, 1'b1, (state.events >= $past(state.events)), "event count decreased")

endmodule

`default_nettype wire
